>>> hw/rtl/dsf_pkg.sv
// Shared types and constants of the spring-damper force pipeline.
// Used by dsf_sqrt, dsf_div, dsf_force and damped_spring_force; no dependencies.
package dsf_pkg;

  localparam int WordW = 32;  // signed Q16.16 vector components
  localparam int ParW  = 31;  // unsigned Q15.16 joint parameters
  localparam int LenW  = 32;  // floor square root of a 64-bit sum
  localparam int QuotW = 17;  // axis magnitude, Q1.16 in [0, 1]
  localparam int FracW = 16;

  localparam logic [ParW-1:0]  MinSepReset = 31'd7;
  localparam logic [WordW-1:0] ForceMax    = 32'h7FFF_FFFF;
  localparam logic [47:0]      FmagMax     = 48'hFFFF_FFFF_FFFF;

  // One joint as it enters the block
  typedef struct packed {
    logic [2:0][WordW-1:0] s;
    logic [2:0][WordW-1:0] v;
    logic [ParW-1:0]       rest;
    logic [ParW-1:0]       k;
    logic [ParW-1:0]       c;
  } joint_t;

  // Joint plus its length
  typedef struct packed {
    joint_t          j;
    logic [LenW-1:0] len;
  } root_t;

  // Unit axis and spring extension, ready for the force products
  typedef struct packed {
    logic                  skip;
    logic                  ext_neg;
    logic [LenW-1:0]       ext_mag;
    logic [2:0]            u_neg;
    logic [2:0][QuotW-1:0] u_mag;
    logic [2:0][WordW-1:0] v;
    logic [ParW-1:0]       k;
    logic [ParW-1:0]       c;
  } axis_t;

  // One result
  typedef struct packed {
    logic [2:0][WordW-1:0] fa;
    logic [2:0][WordW-1:0] fb;
    logic                  skipped;
    logic                  saturated;
  } result_t;

endpackage

>>> hw/rtl/damped_spring_force.sv
// Spring-damper force of one two-body joint, Q16.16, saturating.
// Top level; instantiates dsf_sqrt, dsf_div and dsf_force, uses dsf_pkg.
//
// Input channel (valid_i/ready_o): one joint per request: separation and
// relative velocity vectors, rest length, stiffness and damping.
// Output channel (valid_o/ready_i): force on body A, force on body B (its
// negation), a skipped flag for joints of zero length or shorter than
// min_separation and a saturated flag when any component was clamped.
// Configuration: cfg_we_i writes cfg_wdata_i into min_separation;
// write it only while no request is in flight.
// Pipeline: squares and sum, the square root (one bit per stage),
// classification and the axis division (one quotient bit per stage), the
// force products and the result register. Throughput: one request per cycle
// while the receiver keeps up; a stall holds the pipe as below.
// Reset clears every valid bit and loads min_separation with 7.
// When the receiver stalls, the result register holds; the pipe keeps moving
// and accepting requests until its last stage holds a result, then the
// whole pipe holds in step and ready_o drops.
module damped_spring_force (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] sep_x_i,
  input  logic [31:0] sep_y_i,
  input  logic [31:0] sep_z_i,
  input  logic [31:0] relvel_x_i,
  input  logic [31:0] relvel_y_i,
  input  logic [31:0] relvel_z_i,
  input  logic [30:0] rest_length_i,
  input  logic [30:0] stiffness_i,
  input  logic [30:0] damping_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] force_a_x_o,
  output logic [31:0] force_a_y_o,
  output logic [31:0] force_a_z_o,
  output logic [31:0] force_b_x_o,
  output logic [31:0] force_b_y_o,
  output logic [31:0] force_b_z_o,
  output logic        skipped_o,
  output logic        saturated_o
);

  logic [dsf_pkg::ParW-1:0] min_sep_q;
  dsf_pkg::joint_t  joint;
  dsf_pkg::root_t   root;
  dsf_pkg::axis_t   axis;
  dsf_pkg::result_t res;
  logic             adv;
  logic             root_vld, axis_vld;

  // Hold the short-joint threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sep_q <= dsf_pkg::MinSepReset;
    end else if (cfg_we_i) begin
      min_sep_q <= cfg_wdata_i;
    end
  end

  // Gather the request
  always_comb begin
    joint.s    = {sep_z_i, sep_y_i, sep_x_i};
    joint.v    = {relvel_z_i, relvel_y_i, relvel_x_i};
    joint.rest = rest_length_i;
    joint.k    = stiffness_i;
    joint.c    = damping_i;
  end

  assign ready_o = adv;

  dsf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (valid_i),
    .joint_i (joint),
    .valid_o (root_vld),
    .root_o  (root)
  );

  dsf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (root_vld),
    .root_i    (root),
    .min_sep_i (min_sep_q),
    .valid_o   (axis_vld),
    .axis_o    (axis)
  );

  dsf_force u_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (axis_vld),
    .axis_i  (axis),
    .ready_i (ready_i),
    .adv_o   (adv),
    .valid_o (valid_o),
    .res_o   (res)
  );

  assign force_a_x_o = res.fa[0];
  assign force_a_y_o = res.fa[1];
  assign force_a_z_o = res.fa[2];
  assign force_b_x_o = res.fb[0];
  assign force_b_y_o = res.fb[1];
  assign force_b_z_o = res.fb[2];
  assign skipped_o   = res.skipped;
  assign saturated_o = res.saturated;

endmodule

>>> hw/rtl/dsf_sqrt.sv
// Squares, sum and pipelined floor square root of the separation vector.
// One result bit per stage; depends on dsf_pkg.
module dsf_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  dsf_pkg::joint_t joint_i,
  output logic           valid_o,
  output dsf_pkg::root_t root_o
);

  localparam int Steps = dsf_pkg::LenW;

  typedef struct packed {
    dsf_pkg::joint_t j;
    logic [63:0]     rem;
    logic [Steps-1:0] root;
  } stage_t;

  logic [2:0][31:0] mag;
  logic             sq_vld_q;
  dsf_pkg::joint_t  sq_j_q;
  logic [2:0][63:0] sq_q;
  logic [Steps:0]   vld_q;
  stage_t           st_q [Steps+1];

  // Take component magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = joint_i.s[i][31] ? (32'd0 - joint_i.s[i]) : joint_i.s[i];
    end
  end

  // Square each component
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else if (adv_i) begin
      sq_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_j_q <= joint_i;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= mag[i] * mag[i];
      end
    end
  end

  // Sum the squares, seed the root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0].j    <= sq_j_q;
      st_q[0].rem  <= sq_q[0] + sq_q[1] + sq_q[2];
      st_q[0].root <= '0;
    end
  end

  // Settle one root bit per stage, most significant first
  for (genvar g = 0; g < Steps; g++) begin : g_root
    localparam int Bit = Steps - 1 - g;
    logic [64:0] trial;

    always_comb begin
      trial = ({33'd0, st_q[g].root} << (Bit + 1)) | (65'd1 << (2 * Bit));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[g+1].j <= st_q[g].j;
        if ({1'b0, st_q[g].rem} >= trial) begin
          st_q[g+1].rem  <= st_q[g].rem - trial[63:0];
          st_q[g+1].root <= st_q[g].root | (Steps'(1) << Bit);
        end else begin
          st_q[g+1].rem  <= st_q[g].rem;
          st_q[g+1].root <= st_q[g].root;
        end
      end
    end
  end

  assign valid_o    = vld_q[Steps];
  assign root_o.j   = st_q[Steps].j;
  assign root_o.len = st_q[Steps].root;

endmodule

>>> hw/rtl/dsf_div.sv
// Short-joint test, extension and pipelined restoring division for the unit axis.
// One quotient bit per stage for all three components; depends on dsf_pkg.
module dsf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  dsf_pkg::root_t              root_i,
  input  logic [dsf_pkg::ParW-1:0]    min_sep_i,
  output logic                        valid_o,
  output dsf_pkg::axis_t              axis_o
);

  localparam int Steps = dsf_pkg::QuotW;

  typedef struct packed {
    dsf_pkg::axis_t   a;
    logic [31:0]      len;
    logic [2:0][47:0] rem;
  } stage_t;

  logic [32:0]    ext;
  logic [32:0]    ext_abs;
  logic [2:0][31:0] mag;
  stage_t         prep;
  logic [Steps:0] vld_q;
  stage_t         st_q [Steps+1];

  // Classify the joint and set up the dividends
  always_comb begin
    ext     = {1'b0, root_i.len} - {2'b0, root_i.j.rest};
    ext_abs = ext[32] ? (33'd0 - ext) : ext;
    for (int i = 0; i < 3; i++) begin
      mag[i] = root_i.j.s[i][31] ? (32'd0 - root_i.j.s[i]) : root_i.j.s[i];
    end
    prep.a.skip    = (root_i.len == '0) || (root_i.len < {1'b0, min_sep_i});
    prep.a.ext_neg = ext[32];
    prep.a.ext_mag = ext_abs[31:0];
    for (int i = 0; i < 3; i++) begin
      prep.a.u_neg[i] = root_i.j.s[i][31];
      prep.rem[i]     = {mag[i], 16'd0};
    end
    prep.a.u_mag = '0;
    prep.a.v     = root_i.j.v;
    prep.a.k     = root_i.j.k;
    prep.a.c     = root_i.j.c;
    prep.len     = root_i.len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0] <= prep;
    end
  end

  // Settle one quotient bit per stage in each lane
  for (genvar g = 0; g < Steps; g++) begin : g_quot
    localparam int Bit = Steps - 1 - g;
    logic [48:0] trial;
    stage_t      nxt;

    always_comb begin
      trial = {17'd0, st_q[g].len} << Bit;
      nxt   = st_q[g];
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, st_q[g].rem[i]} >= trial) begin
          nxt.rem[i]     = st_q[g].rem[i] - trial[47:0];
          nxt.a.u_mag[i] = st_q[g].a.u_mag[i] | (Steps'(1) << Bit);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[g+1] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign axis_o  = st_q[Steps].a;

endmodule

>>> hw/rtl/dsf_force.sv
// Spring and damping products, force along the axis, saturation and output register.
// Seven product stages plus the result register; depends on dsf_pkg.
module dsf_force (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dsf_pkg::axis_t   axis_i,
  input  logic             ready_i,
  output logic             adv_o,
  output logic             valid_o,
  output dsf_pkg::result_t res_o
);

  logic [7:1] vld_q;
  logic       out_vld_q;
  logic       out_en;

  // Stage 1: velocity times axis, stiffness times extension
  logic signed [2:0][17:0] u_c;
  logic [2:0][49:0]        f1_prod_q;
  logic [62:0]             f1_kext_q;
  logic                    f1_skip_q, f1_sneg_q;
  logic [2:0]              f1_uneg_q;
  logic [2:0][16:0]        f1_umag_q;
  logic [30:0]             f1_c_q;

  // Stage 2: axial velocity and spring term
  logic signed [51:0] dot_c;
  logic [51:0]        dot_abs_c;
  logic [35:0]        f2_vm_q;
  logic [46:0]        f2_sp_q;
  logic               f2_dneg_q, f2_sneg_q, f2_skip_q;
  logic [2:0]         f2_uneg_q;
  logic [2:0][16:0]   f2_umag_q;
  logic [30:0]        f2_c_q;

  // Stage 3: damping partial products
  logic [50:0]      f3_phi_q;
  logic [46:0]      f3_plo_q;
  logic [46:0]      f3_sp_q;
  logic             f3_dneg_q, f3_sneg_q, f3_skip_q;
  logic [2:0]       f3_uneg_q;
  logic [2:0][16:0] f3_umag_q;

  // Stage 4: damping term
  logic [51:0]      f4_dm_q;
  logic [46:0]      f4_sp_q;
  logic             f4_dneg_q, f4_sneg_q, f4_skip_q;
  logic [2:0]       f4_uneg_q;
  logic [2:0][16:0] f4_umag_q;

  // Stage 5: signed force magnitude
  logic signed [53:0] f_c;
  logic [53:0]      f5_f_q;
  logic             f5_skip_q;
  logic [2:0]       f5_uneg_q;
  logic [2:0][16:0] f5_umag_q;

  // Stage 6: clamped magnitude
  logic [53:0]      fabs_c;
  logic [47:0]      f6_fm_q;
  logic             f6_fneg_q, f6_skip_q;
  logic [2:0]       f6_uneg_q;
  logic [2:0][16:0] f6_umag_q;

  // Stage 7: components
  logic [2:0][64:0] cm_c;
  logic [2:0][48:0] f7_cm_q;
  logic [2:0]       f7_neg_q;
  logic             f7_skip_q;

  // Result
  dsf_pkg::result_t res_c;
  dsf_pkg::result_t res_q;
  logic [2:0][31:0] cmag_c;

  // Advance the pipe when the result register frees up or the last stage is empty
  assign out_en = !out_vld_q || ready_i;
  assign adv_o  = out_en || !vld_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_o) begin
        vld_q <= {vld_q[6:1], valid_i};
      end
      if (out_en) begin
        out_vld_q <= vld_q[7];
      end
    end
  end

  // Stage 1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_c[i] = axis_i.u_neg[i] ? (18'sd0 - $signed({1'b0, axis_i.u_mag[i]}))
                               : $signed({1'b0, axis_i.u_mag[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      for (int i = 0; i < 3; i++) begin
        f1_prod_q[i] <= $signed(axis_i.v[i]) * $signed(u_c[i]);
      end
      f1_kext_q <= axis_i.k * axis_i.ext_mag;
      f1_skip_q <= axis_i.skip;
      f1_sneg_q <= axis_i.ext_neg;
      f1_uneg_q <= axis_i.u_neg;
      f1_umag_q <= axis_i.u_mag;
      f1_c_q    <= axis_i.c;
    end
  end

  // Stage 2
  always_comb begin
    dot_c = $signed(f1_prod_q[0]) + $signed(f1_prod_q[1]) + $signed(f1_prod_q[2]);
    dot_abs_c = dot_c[51] ? (52'd0 - dot_c) : dot_c;
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      f2_vm_q   <= dot_abs_c[51:16];
      f2_dneg_q <= dot_c[51];
      f2_sp_q   <= f1_kext_q[62:16];
      f2_sneg_q <= f1_sneg_q;
      f2_skip_q <= f1_skip_q;
      f2_uneg_q <= f1_uneg_q;
      f2_umag_q <= f1_umag_q;
      f2_c_q    <= f1_c_q;
    end
  end

  // Stage 3
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      f3_phi_q  <= f2_c_q * f2_vm_q[35:16];
      f3_plo_q  <= f2_c_q * f2_vm_q[15:0];
      f3_sp_q   <= f2_sp_q;
      f3_dneg_q <= f2_dneg_q;
      f3_sneg_q <= f2_sneg_q;
      f3_skip_q <= f2_skip_q;
      f3_uneg_q <= f2_uneg_q;
      f3_umag_q <= f2_umag_q;
    end
  end

  // Stage 4
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      f4_dm_q   <= {1'b0, f3_phi_q} + {21'd0, f3_plo_q[46:16]};
      f4_sp_q   <= f3_sp_q;
      f4_dneg_q <= f3_dneg_q;
      f4_sneg_q <= f3_sneg_q;
      f4_skip_q <= f3_skip_q;
      f4_uneg_q <= f3_uneg_q;
      f4_umag_q <= f3_umag_q;
    end
  end

  // Stage 5
  always_comb begin
    f_c = (f4_sneg_q ? (54'sd0 - $signed({7'd0, f4_sp_q})) : $signed({7'd0, f4_sp_q}))
        + (f4_dneg_q ? (54'sd0 - $signed({2'd0, f4_dm_q})) : $signed({2'd0, f4_dm_q}));
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      f5_f_q    <= f_c;
      f5_skip_q <= f4_skip_q;
      f5_uneg_q <= f4_uneg_q;
      f5_umag_q <= f4_umag_q;
    end
  end

  // Stage 6
  always_comb begin
    fabs_c = f5_f_q[53] ? (54'd0 - f5_f_q) : f5_f_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      f6_fm_q   <= (fabs_c > {6'd0, dsf_pkg::FmagMax}) ? dsf_pkg::FmagMax : fabs_c[47:0];
      f6_fneg_q <= f5_f_q[53];
      f6_skip_q <= f5_skip_q;
      f6_uneg_q <= f5_uneg_q;
      f6_umag_q <= f5_umag_q;
    end
  end

  // Stage 7
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm_c[i] = f6_fm_q * f6_umag_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      for (int i = 0; i < 3; i++) begin
        f7_cm_q[i]  <= cm_c[i][64:16];
        f7_neg_q[i] <= f6_fneg_q ^ f6_uneg_q[i];
      end
      f7_skip_q <= f6_skip_q;
    end
  end

  // Saturate, apply sign, negate for body B; zero a skipped joint
  always_comb begin
    res_c.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (f7_cm_q[i] > {17'd0, dsf_pkg::ForceMax}) begin
        cmag_c[i]       = dsf_pkg::ForceMax;
        res_c.saturated = 1'b1;
      end else begin
        cmag_c[i] = f7_cm_q[i][31:0];
      end
      res_c.fa[i] = f7_neg_q[i] ? (32'd0 - cmag_c[i]) : cmag_c[i];
      res_c.fb[i] = 32'd0 - res_c.fa[i];
    end
    res_c.skipped = f7_skip_q;
    if (f7_skip_q) begin
      res_c.fa        = '0;
      res_c.fb        = '0;
      res_c.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      res_q <= res_c;
    end
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;

  // A skipped joint carries no force and no clamp
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.skipped |-> (res_o.fa == '0) && (res_o.fb == '0) && !res_o.saturated)
    else $error("skipped result with nonzero force");

  // Body B always gets the exact negation
  a_b_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.fb[0] == 32'd0 - res_o.fa[0]) && (res_o.fb[1] == 32'd0 - res_o.fa[1])
             && (res_o.fb[2] == 32'd0 - res_o.fa[2]))
    else $error("force on B is not the negation of A");

  // The most negative code never appears
  a_sym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.fa[0] != 32'h8000_0000) && (res_o.fa[1] != 32'h8000_0000)
             && (res_o.fa[2] != 32'h8000_0000))
    else $error("force outside symmetric range");

  // A clamp leaves at least one component at full scale
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.saturated |->
      (res_o.fa[0] == dsf_pkg::ForceMax) || (res_o.fb[0] == dsf_pkg::ForceMax)
   || (res_o.fa[1] == dsf_pkg::ForceMax) || (res_o.fb[1] == dsf_pkg::ForceMax)
   || (res_o.fa[2] == dsf_pkg::ForceMax) || (res_o.fb[2] == dsf_pkg::ForceMax))
    else $error("saturated flag without a full-scale component");

endmodule

>>> tb/damped_spring_force_chk.sv
// Checker for damped_spring_force: watches both channels and the register port,
// predicts each result in Q16.16 and compares it with the block's output.
// Depends on dsf_pkg for the result type and the force limits.
module damped_spring_force_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        valid_i,
  input  logic        ready_o,
  input  logic [31:0] sep_x_i,
  input  logic [31:0] sep_y_i,
  input  logic [31:0] sep_z_i,
  input  logic [31:0] relvel_x_i,
  input  logic [31:0] relvel_y_i,
  input  logic [31:0] relvel_z_i,
  input  logic [30:0] rest_length_i,
  input  logic [30:0] stiffness_i,
  input  logic [30:0] damping_i,
  input  logic        valid_o,
  input  logic        ready_i,
  input  logic [31:0] force_a_x_o,
  input  logic [31:0] force_a_y_o,
  input  logic [31:0] force_a_z_o,
  input  logic [31:0] force_b_x_o,
  input  logic [31:0] force_b_y_o,
  input  logic [31:0] force_b_z_o,
  input  logic        skipped_o,
  input  logic        saturated_o,
  output int          fail_count_o,
  output int          pending_o
);

  dsf_pkg::result_t force_q[$];
  logic    [30:0]   min_sep_q;

  function automatic longint unsigned abs64(input longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  // Spring term along the axis plus damping of the axial velocity
  function automatic dsf_pkg::result_t joint_force(input logic [31:0] sep[3],
                                                   input logic [31:0] vel[3],
                                                   input logic [30:0] rest,
                                                   input logic [30:0] k,
                                                   input logic [30:0] c,
                                                   input logic [30:0] min_sep);
    longint           s[3], v[3], u[3], fa[3], nfa;
    longint           ext, spring, dot, vax, damp, f;
    longint unsigned  sum, n, len, bt, sp, vm, dm, fm, cm, k64, c64;
    dsf_pkg::result_t r;
    r   = '0;
    sum = 0;
    k64 = k;
    c64 = c;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'($signed(sep[i]));
      v[i] = longint'($signed(vel[i]));
      sum += abs64(s[i]) * abs64(s[i]);
    end
    // floor square root of the Q32.32 sum
    n   = sum;
    len = 0;
    bt  = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= len + bt) begin
        n   -= len + bt;
        len  = (len >> 1) + bt;
      end else begin
        len >>= 1;
      end
      bt >>= 2;
    end
    if (len == 0 || len < min_sep) begin
      r.skipped = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) u[i] = (s[i] * 65536) / longint'(len);
    ext    = longint'(len) - longint'({33'd0, rest});
    sp     = (k64 * abs64(ext)) >> 16;
    spring = ext < 0 ? -longint'(sp) : longint'(sp);
    dot    = 0;
    for (int i = 0; i < 3; i++) dot += v[i] * u[i];
    vax  = dot < 0 ? -longint'(abs64(dot) >> 16) : longint'(abs64(dot) >> 16);
    vm   = abs64(vax);
    dm   = c64 * (vm >> 16) + ((c64 * (vm & 64'hFFFF)) >> 16);
    damp = vax < 0 ? -longint'(dm) : longint'(dm);
    f    = spring + damp;
    fm   = abs64(f);
    if (fm > {16'd0, dsf_pkg::FmagMax}) fm = {16'd0, dsf_pkg::FmagMax};
    for (int i = 0; i < 3; i++) begin
      cm = (fm * abs64(u[i])) >> 16;
      if (cm > {32'd0, dsf_pkg::ForceMax}) begin
        cm          = {32'd0, dsf_pkg::ForceMax};
        r.saturated = 1'b1;
      end
      fa[i]   = ((f < 0) != (u[i] < 0)) ? -longint'(cm) : longint'(cm);
      nfa     = -fa[i];
      r.fa[i] = fa[i][31:0];
      r.fb[i] = nfa[31:0];
    end
    return r;
  endfunction

  // Report one mismatching field
  function automatic void report(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    if (fail_count_o < 10)
      $display("mismatch %s: expected %h, got %h", field, exp_v, act_v);
    fail_count_o++;
  endfunction

  assign pending_o = force_q.size();

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0]      sep[3], vel[3];
    dsf_pkg::result_t want, got;
    if (!rst_ni) begin
      min_sep_q <= dsf_pkg::MinSepReset;
    end else begin
      if (valid_i && ready_o) begin
        sep = '{sep_x_i, sep_y_i, sep_z_i};
        vel = '{relvel_x_i, relvel_y_i, relvel_z_i};
        force_q.push_back(joint_force(sep, vel, rest_length_i, stiffness_i,
                                      damping_i, min_sep_q));
      end
      if (valid_o && ready_i) begin
        got.fa        = {force_a_z_o, force_a_y_o, force_a_x_o};
        got.fb        = {force_b_z_o, force_b_y_o, force_b_x_o};
        got.skipped   = skipped_o;
        got.saturated = saturated_o;
        if (force_q.size() == 0) begin
          report("unexpected result", 32'd0, 32'd1);
        end else begin
          want = force_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got.fa[i] !== want.fa[i]) report($sformatf("force_a[%0d]", i),
                                                 want.fa[i], got.fa[i]);
            if (got.fb[i] !== want.fb[i]) report($sformatf("force_b[%0d]", i),
                                                 want.fb[i], got.fb[i]);
          end
          if (got.skipped !== want.skipped)
            report("skipped", {31'd0, want.skipped}, {31'd0, got.skipped});
          if (got.saturated !== want.saturated)
            report("saturated", {31'd0, want.saturated}, {31'd0, got.saturated});
        end
      end
      if (cfg_we_i) min_sep_q <= cfg_wdata_i;
    end
  end

  initial fail_count_o = 0;

endmodule

>>> tb/damped_spring_force_tb.sv
// Testbench top for damped_spring_force: drives joints and register writes,
// stalls both channels at random and gives the verdict from the checker.
// Depends on damped_spring_force, damped_spring_force_chk and dsf_pkg.
module damped_spring_force_tb;

  localparam int DrainCycles = 70;
  localparam int CycleLimit  = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [31:0] sep_x_i = '0, sep_y_i = '0, sep_z_i = '0;
  logic [31:0] relvel_x_i = '0, relvel_y_i = '0, relvel_z_i = '0;
  logic [30:0] rest_length_i = '0, stiffness_i = '0, damping_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [31:0] force_a_x_o, force_a_y_o, force_a_z_o;
  logic [31:0] force_b_x_o, force_b_y_o, force_b_z_o;
  logic        skipped_o, saturated_o;
  int          fail_count_o, pending_o;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycles = 0;

  damped_spring_force u_dut (.*);
  damped_spring_force_chk u_chk (.*);

  always #5 clk_i = ~clk_i;

  // Stall the receiver at random
  always @(negedge clk_i) begin
    ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL damped_spring_force");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(6, 28);
    endcase
  endfunction

  function automatic logic [30:0] rand_param();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      default: return 31'($urandom >> $urandom_range(4, 24));
    endcase
  endfunction

  // Offer one request and hold it until accepted; called at a falling edge
  task automatic send_joint(input logic [31:0] sx, sy, sz, vx, vy, vz,
                            input logic [30:0] rest, k, c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i       <= 1'b1;
    sep_x_i       <= sx;
    sep_y_i       <= sy;
    sep_z_i       <= sz;
    relvel_x_i    <= vx;
    relvel_y_i    <= vy;
    relvel_z_i    <= vz;
    rest_length_i <= rest;
    stiffness_i   <= k;
    damping_i     <= c;
    do @(posedge clk_i); while (!ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    send_joint(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
               rand_word(), rand_param(), rand_param(), rand_param());
  endtask

  // Hold off until every result is back and the pipe is empty
  task automatic drain();
    valid_i <= 1'b0;
    while (pending_o != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_min_sep(input logic [30:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [30:0] seg_cfg[6];
    int          seg_items[6];
    seg_cfg   = '{31'd0, 31'd7, 31'h7FFF_FFFF, 31'h0001_0000, 31'd0, 31'h7FFF_FFFF};
    seg_items = '{250, 250, 30, 220, 230, 30};
    seg_cfg[3] = 31'($urandom >> $urandom_range(8, 24));
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed joints at the reset threshold
    send_joint('0, '0, '0, '0, '0, '0, '0, 31'h10000, 31'h10000);
    send_joint(32'd6, '0, '0, '0, '0, '0, '0, 31'h10000, '0);
    send_joint(32'd7, '0, '0, '0, '0, '0, '0, 31'h10000, '0);
    send_joint(32'h0001_0000, '0, '0, '0, '0, '0, 31'h0002_0000, 31'h0001_0000, '0);
    send_joint('0, 32'hFFFE_0000, '0, '0, 32'h0003_0000, '0, '0, 31'h0004_0000,
               31'h0000_8000);
    send_joint('0, '0, 32'h0005_0000, '0, '0, 32'hFFF0_0000, 31'h7FFF_FFFF,
               31'h0001_0000, 31'h7FFF_FFFF);
    send_joint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, '0,
               31'h7FFF_FFFF, '0);
    send_joint(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
               31'h7FFF_FFFF);
    send_joint(32'h0003_0000, 32'h0004_0000, '0, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, '0, '0, 31'h7FFF_FFFF);
    send_joint(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_1000,
               32'hFFFF_F000, 32'h0000_0800, 31'h0001_8000, 31'h0010_0000,
               31'h0002_0000);
    send_joint(32'h0000_0100, 32'h0000_0100, 32'h0000_0100, '0, '0, '0, '0, '0, '0);
    send_joint(32'h0100_0000, '0, '0, '0, '0, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0);

    // Random phases, each under its own threshold and stall pattern
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      write_min_sep(seg_cfg[seg]);
      send_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 88 : 0;
      recv_idle_pct = (seg < 2) ? 88 : (seg < 4) ? 14 : 0;
      if (seg_cfg[seg] == 0) send_joint('0, '0, '0, '0, '0, '0, '0, 31'h1, 31'h1);
      repeat (seg_items[seg]) send_random();
    end

    drain();
    if (fail_count_o == 0) begin
      $display("PASS damped_spring_force");
    end else begin
      $display("FAIL damped_spring_force");
    end
    $finish;
  end

endmodule
